// ===== src/cpps_pkg.sv =====
// ----------------------------------------------------------------------------
// cpps_pkg: shared types and constants for the closest pair point store
// Item and result layouts, opcode and status codes, and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cpps_pkg;

  // Field widths fixed by the item and result layouts
  localparam int COORD_W  = 16;
  localparam int DIST_W   = 33;
  localparam int COUNT_W  = 7;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FEW  = 2'd2;

  // One input item
  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } item_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic [DIST_W-1:0]         min_dist_sq;
    logic [COUNT_W-1:0]        point_count;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;        // latch the point of the accepted item
    logic                wr_en;       // write point memory
    logic                wr_item;     // write data is the latched point
    logic                rd_del;      // read for the delete sweep
    logic                rd_pair;     // read a pair for the distance pipe
    logic                rd_last;     // this read is the last of the sweep
    logic                clear_best;  // forget the running minimum
    logic                emit;        // register the result
    logic                with_pair;   // result carries the closest pair
    logic [STATUS_W-1:0] status;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic del_valid;  // delete read data is present
    logic keep;       // that point has nonzero y
    logic del_last;   // that point is the last one of the sweep
    logic pair_done;  // last pair has been compared
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/cpps_dpath.sv =====
// ----------------------------------------------------------------------------
// cpps_dpath: point memory and distance pipeline
// Holds the points in a two-read, one-write memory, compacts it on delete,
// and runs each pair through difference, square and compare stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cpps_dpath #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire cpps_pkg::item_t                      item,
  input  wire cpps_pkg::ctrl_cmd_t                  cmd,
  input  wire logic [$clog2(MAX_POINTS)-1:0]        wr_addr,
  input  wire logic [$clog2(MAX_POINTS)-1:0]        rd_addr_a,
  input  wire logic [$clog2(MAX_POINTS)-1:0]        rd_addr_b,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0]      count,
  output cpps_pkg::dp_stat_t                        stat,
  output cpps_pkg::result_t                         result,
  output logic                                      done
);

  localparam int CD = cpps_pkg::COORD_W;
  localparam int PW = 2 * CD;
  localparam int SW = 2 * CD;  // width of one square

  // Point memory, each word {x, y}; physical order is insertion order
  logic [PW-1:0] mem [MAX_POINTS];

  logic [PW-1:0] pt_in;
  logic [PW-1:0] rd_a, rd_b;
  logic          v1_del, v1_pair, last1;

  logic [PW-1:0] pa2, pb2, pa3, pb3;
  logic [CD-1:0] dx2, dy2;
  logic          v2, last2, v3, last3;
  logic [SW-1:0] sqx3, sqy3;

  logic [PW-1:0]                best_pa, best_pb;
  logic [cpps_pkg::DIST_W-1:0]  best_d;
  logic                         best_valid;

  logic signed [CD:0]           diff_x, diff_y;
  logic [CD:0]                  abs_x, abs_y;
  logic [cpps_pkg::DIST_W-1:0]  sum3;

  // Latch the point of an accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_in <= {item.x_coord, item.y_coord};
    end
  end

  // Memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_item ? pt_in : rd_a;
    end
    if (cmd.rd_del || cmd.rd_pair) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

  // Read stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1_del  <= 1'b0;
      v1_pair <= 1'b0;
    end else begin
      v1_del  <= cmd.rd_del;
      v1_pair <= cmd.rd_pair;
    end
    last1 <= cmd.rd_last;
  end

  // Status back to the controller
  always_comb begin
    stat.del_valid = v1_del;
    stat.keep      = |rd_a[CD-1:0];
    stat.del_last  = v1_del & last1;
    stat.pair_done = v3 & last3;
  end

  // Absolute coordinate differences
  always_comb begin
    diff_x = $signed({rd_a[PW-1], rd_a[PW-1:CD]}) - $signed({rd_b[PW-1], rd_b[PW-1:CD]});
    diff_y = $signed({rd_a[CD-1], rd_a[CD-1:0]}) - $signed({rd_b[CD-1], rd_b[CD-1:0]});
    abs_x  = diff_x[CD] ? (CD+1)'(-diff_x) : (CD+1)'(diff_x);
    abs_y  = diff_y[CD] ? (CD+1)'(-diff_y) : (CD+1)'(diff_y);
  end

  // Difference stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1_pair;
    end
    last2 <= last1;
    pa2   <= rd_a;
    pb2   <= rd_b;
    dx2   <= abs_x[CD-1:0];
    dy2   <= abs_y[CD-1:0];
  end

  // Square stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    last3 <= last2;
    pa3   <= pa2;
    pb3   <= pb2;
    sqx3  <= dx2 * dx2;
    sqy3  <= dy2 * dy2;
  end

  // Sum and keep the first strict minimum
  assign sum3 = cpps_pkg::DIST_W'(sqx3) + cpps_pkg::DIST_W'(sqy3);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (cmd.clear_best) begin
      best_valid <= 1'b0;
    end else if (v3 && (!best_valid || sum3 < best_d)) begin
      best_valid <= 1'b1;
    end
    if (v3 && (!best_valid || sum3 < best_d)) begin
      best_d  <= sum3;
      best_pa <= pa3;
      best_pb <= pb3;
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      result.status      <= cmd.status;
      result.point_count <= cpps_pkg::COUNT_W'(count);
      if (cmd.with_pair) begin
        result.first_x     <= best_pa[PW-1:CD];
        result.first_y     <= best_pa[CD-1:0];
        result.second_x    <= best_pb[PW-1:CD];
        result.second_y    <= best_pb[CD-1:0];
        result.min_dist_sq <= best_d;
      end else begin
        result.first_x     <= '0;
        result.first_y     <= '0;
        result.second_x    <= '0;
        result.second_y    <= '0;
        result.min_dist_sq <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/cpps_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpps_ctrl: operation sequencer
// Decodes the accepted item, keeps the point count and walks the memory
// for insert, delete compaction and the all-pairs query.
// ----------------------------------------------------------------------------
`default_nettype none

module cpps_ctrl #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [cpps_pkg::OP_W-1:0]            opcode,
  input  wire cpps_pkg::dp_stat_t                   stat,
  output logic                                      busy,
  output cpps_pkg::ctrl_cmd_t                       cmd,
  output logic [$clog2(MAX_POINTS)-1:0]             wr_addr,
  output logic [$clog2(MAX_POINTS)-1:0]             rd_addr_a,
  output logic [$clog2(MAX_POINTS)-1:0]             rd_addr_b,
  output logic [$clog2(MAX_POINTS+1)-1:0]           count
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL_RD,
    S_DEL_WAIT,
    S_Q_RUN,
    S_Q_WAIT,
    S_DONE
  } state_t;

  state_t                        state;
  logic [cpps_pkg::OP_W-1:0]     op;
  logic [cpps_pkg::STATUS_W-1:0] status_r;
  logic [AW-1:0]                 ri;      // delete read index
  logic [CW-1:0]                 w;       // delete write index
  logic [CW-1:0]                 w_next;
  logic [AW-1:0]                 pi, pj;  // query pair, physical indexes
  logic [AW-1:0]                 last_idx;
  logic                          accept;
  logic                          del_last_rd;
  logic                          q_last_rd;

  assign busy        = (state != S_IDLE);
  assign accept      = start && (state == S_IDLE);
  assign last_idx    = AW'(count - CW'(1));
  assign del_last_rd = (ri == last_idx);
  assign q_last_rd   = (pi == AW'(1)) && (pj == '0);
  assign w_next      = w + CW'(stat.del_valid & stat.keep);

  // Commands to the datapath
  always_comb begin
    cmd            = '0;
    cmd.load       = accept;
    cmd.clear_best = accept;
    wr_addr        = w[AW-1:0];
    rd_addr_a      = pi;
    rd_addr_b      = pj;
    unique case (state)
      S_INS: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_item = 1'b1;
        wr_addr     = count[AW-1:0];
      end
      S_DEL_RD: begin
        cmd.rd_del  = 1'b1;
        cmd.rd_last = del_last_rd;
        rd_addr_a   = ri;
        rd_addr_b   = ri;
      end
      S_Q_RUN: begin
        cmd.rd_pair = 1'b1;
        cmd.rd_last = q_last_rd;
      end
      S_DONE: begin
        cmd.emit      = 1'b1;
        cmd.status    = status_r;
        cmd.with_pair = (op == cpps_pkg::OP_QUERY) && (status_r == cpps_pkg::ST_DONE);
      end
      S_IDLE, S_DEL_WAIT, S_Q_WAIT: begin
      end
      default: begin
      end
    endcase
    // Compaction: a kept point goes to the write index
    if (stat.del_valid && stat.keep) begin
      cmd.wr_en = 1'b1;
    end
  end

  // State, count and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= opcode;
            unique case (opcode)
              cpps_pkg::OP_INSERT: begin
                if (count == CW'(MAX_POINTS)) begin
                  status_r <= cpps_pkg::ST_FULL;
                  state    <= S_DONE;
                end else begin
                  status_r <= cpps_pkg::ST_DONE;
                  state    <= S_INS;
                end
              end
              cpps_pkg::OP_DELETE: begin
                status_r <= cpps_pkg::ST_DONE;
                ri       <= '0;
                w        <= '0;
                state    <= (count == '0) ? S_DONE : S_DEL_RD;
              end
              cpps_pkg::OP_QUERY: begin
                pi <= AW'(count - CW'(1));
                pj <= AW'(count - CW'(2));
                if (count < CW'(2)) begin
                  status_r <= cpps_pkg::ST_FEW;
                  state    <= S_DONE;
                end else begin
                  status_r <= cpps_pkg::ST_DONE;
                  state    <= S_Q_RUN;
                end
              end
              default: begin
                status_r <= cpps_pkg::ST_DONE;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DEL_RD: begin
          w <= w_next;
          if (del_last_rd) begin
            state <= S_DEL_WAIT;
          end else begin
            ri <= ri + AW'(1);
          end
        end
        S_DEL_WAIT: begin
          w <= w_next;
          if (stat.del_last) begin
            count <= w_next;
            state <= S_DONE;
          end
        end
        S_Q_RUN: begin
          // Newest first: walk physical indexes downward
          if (q_last_rd) begin
            state <= S_Q_WAIT;
          end else if (pj == '0) begin
            pi <= pi - AW'(1);
            pj <= pi - AW'(2);
          end else begin
            pj <= pj - AW'(1);
          end
        end
        S_Q_WAIT: begin
          if (stat.pair_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/closest_pair_point_store.sv =====
// ----------------------------------------------------------------------------
// closest_pair_point_store: bounded 2-D point store with closest pair query
//
//   Channel   Ports                 Transfer
//   -------   -------------------   ----------------------------------
//   item      start, busy, item     edge with start high and busy low
//   result    done, result          every edge that ends a done cycle
//
// With n points stored, a delete makes one memory read per point, and a
// query takes one pair per cycle through the two read ports of the point
// memory, then three pipeline stages to drain.
// Reset is synchronous and clears the count; memory contents need none.
// busy is high from the cycle after a transfer until the result is built;
// the result register holds the result alone, so the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_pair_point_store #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire cpps_pkg::item_t   item,
  output logic                   done,
  output cpps_pkg::result_t      result
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  cpps_pkg::ctrl_cmd_t cmd;
  cpps_pkg::dp_stat_t  stat;
  logic [AW-1:0]       wr_addr, rd_addr_a, rd_addr_b;
  logic [CW-1:0]       count;

  // Sequencer
  cpps_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (item.opcode),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .count     (count)
  );

  // Memory and distance pipeline
  cpps_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .count     (count),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without work in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond store size");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == cpps_pkg::ST_FULL) |-> count == CW'(MAX_POINTS))
    else $error("store full reported on a store that is not full");

endmodule

`default_nettype wire
